[src/whdq_pkg.sv]
// Shared types and constants for the window/hysteresis/debounce qualifier.
// Used by every module under src; depends on nothing.
`default_nettype none

package whdq_pkg;

  localparam int unsigned ReadsPerSample = 8;
  localparam int unsigned AdcMax         = 4095;
  localparam int unsigned SumW           = 15;   // 8 readings of 12 bits
  localparam int unsigned AvgShift       = 3;    // log2 of ReadsPerSample
  localparam int unsigned QDepth         = 2;

  localparam logic [10:0] HystReset     = 11'd50;
  localparam logic [15:0] IntervalReset = 16'd50;
  localparam logic [15:0] DebounceReset = 16'd200;
  localparam logic [11:0] DefLoReset    = 12'd1000;
  localparam logic [11:0] DefHiReset    = 12'd3000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_START = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_HYST     = 3'd0,
    REG_INTERVAL = 3'd1,
    REG_DEBOUNCE = 3'd2,
    REG_DEF_LO   = 3'd3,
    REG_DEF_HI   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [11:0] reading_0;
    logic [11:0] reading_1;
    logic [11:0] reading_2;
    logic [11:0] reading_3;
    logic [11:0] reading_4;
    logic [11:0] reading_5;
    logic [11:0] reading_6;
    logic [11:0] reading_7;
    logic [15:0] new_lower;
    logic [15:0] new_upper;
  } in_t;

  typedef struct packed {
    logic        state_open;
    logic [11:0] level;
    logic        changed;
    logic        sampled;
    logic        bounds_rejected;
  } out_t;

  typedef struct packed {
    logic [10:0] hysteresis;
    logic [15:0] sample_interval_ms;
    logic [15:0] debounce_ms;
    logic [11:0] default_lower;
    logic [11:0] default_upper;
  } cfg_t;

  // Word passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [11:0] avg;
    logic        bounds_ok;
    logic [11:0] lo;
    logic [11:0] hi;
  } fq_t;

endpackage

`default_nettype wire

[src/window_hysteresis_debounce_qualifier_top.sv]
// Door open/closed qualifier for a Hall-sensor level: window comparator with
// hysteresis and a time-based debounce, behind queue-style ports and an APB
// register port. Depends on whdq_pkg, whdq_cfg, whdq_front and whdq_back.
//
// The block takes one input word per clock while full is low, and returns
// exactly one result word per input word, in order. A pushed word is averaged
// and window-checked by the front end into a two-word queue; the back end
// applies it to the door state and places the result in a two-word output
// queue. A result is registered in the front queue and then in the output
// queue before it shows on the result ports; it can be popped at the next
// edge. The sustained rate, one word per cycle while the output queue is not
// full, is set by the back end's state update (sampling gate, classification
// and debounce for each word in turn). full rises only when both queues are
// backed up by a stalled pop. Configuration registers sit at byte addresses
// 0x00 (hysteresis), 0x04 (sample interval), 0x08 (debounce), 0x0C and 0x10
// (default lower and upper window bounds); write them only while idle.
`default_nettype none

module window_hysteresis_debounce_qualifier_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output      logic [31:0]    prdata,
  output      logic           pready,
  input  wire logic           push,
  output      logic           full,
  input  wire whdq_pkg::in_t  in_i,
  output      logic           empty,
  input  wire logic           pop,
  output      whdq_pkg::out_t out_o
);

  whdq_pkg::cfg_t cfg;
  whdq_pkg::fq_t  fq_head;
  logic           fq_valid;
  logic           fq_pop;

  whdq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  whdq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push       (push),
    .in_i       (in_i),
    .full       (full),
    .fq_valid_o (fq_valid),
    .fq_head_o  (fq_head),
    .fq_pop_i   (fq_pop)
  );

  whdq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .fq_valid_i (fq_valid),
    .fq_head_i  (fq_head),
    .fq_pop_o   (fq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o)
  );

  // The back end only takes a word the front end actually holds.
  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_pop |-> fq_valid)
    else $error("back end popped an empty front queue");

  // A committed change always comes from a taken sample.
  a_change_sampled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.changed) |-> out_o.sampled)
    else $error("change reported without a sample");

  // Window rejection and tick flags never share a result.
  a_reject_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.bounds_rejected) |-> (!out_o.sampled && !out_o.changed))
    else $error("rejected bounds alongside tick flags");

endmodule

`default_nettype wire

[src/whdq_cfg.sv]
// APB register file for the qualifier's five configuration registers.
// Depends on whdq_pkg.
`default_nettype none

module whdq_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output      logic [31:0]   prdata,
  output      logic          pready,
  output      whdq_pkg::cfg_t cfg_o
);

  whdq_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        whdq_pkg::REG_HYST:     cfg_d.hysteresis         = pwdata[10:0];
        whdq_pkg::REG_INTERVAL: cfg_d.sample_interval_ms = pwdata[15:0];
        whdq_pkg::REG_DEBOUNCE: cfg_d.debounce_ms        = pwdata[15:0];
        whdq_pkg::REG_DEF_LO:   cfg_d.default_lower      = pwdata[11:0];
        whdq_pkg::REG_DEF_HI:   cfg_d.default_upper      = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      whdq_pkg::REG_HYST:     prdata = {21'd0, cfg_q.hysteresis};
      whdq_pkg::REG_INTERVAL: prdata = {16'd0, cfg_q.sample_interval_ms};
      whdq_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
      whdq_pkg::REG_DEF_LO:   prdata = {20'd0, cfg_q.default_lower};
      whdq_pkg::REG_DEF_HI:   prdata = {20'd0, cfg_q.default_upper};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis         <= whdq_pkg::HystReset;
      cfg_q.sample_interval_ms <= whdq_pkg::IntervalReset;
      cfg_q.debounce_ms        <= whdq_pkg::DebounceReset;
      cfg_q.default_lower      <= whdq_pkg::DefLoReset;
      cfg_q.default_upper      <= whdq_pkg::DefHiReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[src/whdq_front.sv]
// Front end: accepts input words, averages the readings, checks the
// requested window and queues the result for the back end. Depends on whdq_pkg.
`default_nettype none

module whdq_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire whdq_pkg::cfg_t cfg_i,
  input  wire logic           push,
  input  wire whdq_pkg::in_t  in_i,
  output      logic           full,
  output      logic           fq_valid_o,
  output      whdq_pkg::fq_t  fq_head_o,
  input  wire logic           fq_pop_i
);

  whdq_pkg::fq_t mem_q [whdq_pkg::QDepth];
  logic          wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  logic [12:0]   s01, s23, s45, s67;
  logic [13:0]   s03, s47;
  logic [whdq_pkg::SumW-1:0] sum;
  logic [11:0]   avg;
  logic          ok;
  logic [15:0]   span;
  logic [11:0]   twice_h;
  whdq_pkg::fq_t word;

  // Adder tree over the eight readings.
  assign s01 = {1'b0, in_i.reading_0} + {1'b0, in_i.reading_1};
  assign s23 = {1'b0, in_i.reading_2} + {1'b0, in_i.reading_3};
  assign s45 = {1'b0, in_i.reading_4} + {1'b0, in_i.reading_5};
  assign s67 = {1'b0, in_i.reading_6} + {1'b0, in_i.reading_7};
  assign s03 = {1'b0, s01} + {1'b0, s23};
  assign s47 = {1'b0, s45} + {1'b0, s67};
  assign sum = {1'b0, s03} + {1'b0, s47};
  assign avg = sum[whdq_pkg::SumW-1:whdq_pkg::AvgShift];

  // Window check: upper above lower, span wider than both margins, in range.
  assign span    = in_i.new_upper - in_i.new_lower;
  assign twice_h = {cfg_i.hysteresis, 1'b0};
  assign ok      = (in_i.new_upper > in_i.new_lower) &&
                   (span > {4'd0, twice_h}) &&
                   (in_i.new_upper <= 16'(whdq_pkg::AdcMax));

  always_comb begin
    word.action    = in_i.action;
    word.now_ms    = in_i.now_ms;
    word.avg       = avg;
    word.bounds_ok = ok;
    // A start with a bad window falls back to the defaults, unchecked.
    if (ok || (in_i.action != whdq_pkg::ACT_START)) begin
      word.lo = in_i.new_lower[11:0];
      word.hi = in_i.new_upper[11:0];
    end else begin
      word.lo = cfg_i.default_lower;
      word.hi = cfg_i.default_upper;
    end
  end

  assign full       = (cnt_q == 2'(whdq_pkg::QDepth));
  assign fq_valid_o = (cnt_q != 2'd0);
  assign fq_head_o  = mem_q[rptr_q];
  assign do_push    = push & ~full;
  assign do_pop     = fq_pop_i & fq_valid_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[src/whdq_back.sv]
// Back end: holds the door state, applies each queued word (sampling gate,
// window classification, debounce) and queues one result word per item.
// Depends on whdq_pkg.
`default_nettype none

module whdq_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire whdq_pkg::cfg_t cfg_i,
  input  wire logic           fq_valid_i,
  input  wire whdq_pkg::fq_t  fq_head_i,
  output      logic           fq_pop_o,
  output      logic           empty,
  input  wire logic           pop,
  output      whdq_pkg::out_t out_o
);

  // Qualifier state
  logic        open_q, open_d;
  logic [11:0] level_q, level_d;
  logic [11:0] lo_q, lo_d, hi_q, hi_d;
  logic [31:0] sample_t_q, sample_t_d;
  logic        pv_q, pv_d;
  logic        ptc_q, ptc_d;
  logic [31:0] pst_q, pst_d;

  // Result queue
  whdq_pkg::out_t omem_q [whdq_pkg::QDepth];
  logic           owptr_q, owptr_d, orptr_q, orptr_d;
  logic [1:0]     ocnt_q, ocnt_d;
  logic           ofull, do_opop;

  logic           go;
  whdq_pkg::fq_t  w;
  whdq_pkg::out_t res;
  logic [11:0]    c_lvl, c_lo, c_hi;
  logic [12:0]    lvl_h, lo_h, hi_h;
  logic           c_closed, c_open;
  logic [31:0]    since_sample, since_pending;
  logic           take, settled;

  assign w        = fq_head_i;
  assign ofull    = (ocnt_q == 2'(whdq_pkg::QDepth));
  assign go       = fq_valid_i & ~ofull;
  assign fq_pop_o = go;

  // Classifier inputs: set reclassifies the held level against the new window,
  // start uses the window the front end chose, tick the current window.
  always_comb begin
    c_lvl = w.avg;
    c_lo  = lo_q;
    c_hi  = hi_q;
    case (w.action)
      whdq_pkg::ACT_SET: begin
        c_lvl = level_q;
        c_lo  = w.lo;
        c_hi  = w.hi;
      end
      whdq_pkg::ACT_START: begin
        c_lo  = w.lo;
        c_hi  = w.hi;
      end
      default: ;
    endcase
  end

  assign lvl_h    = {1'b0, c_lvl} + {2'b0, cfg_i.hysteresis};
  assign lo_h     = {1'b0, c_lo} + {2'b0, cfg_i.hysteresis};
  assign hi_h     = {1'b0, c_hi} + {2'b0, cfg_i.hysteresis};
  assign c_closed = (lvl_h < {1'b0, c_lo}) || ({1'b0, c_lvl} > hi_h);
  assign c_open   = ~c_closed && ({1'b0, c_lvl} > lo_h) && (lvl_h < {1'b0, c_hi});

  assign since_sample  = w.now_ms - sample_t_q;
  assign since_pending = w.now_ms - pst_q;
  assign take          = since_sample >= {16'd0, cfg_i.sample_interval_ms};
  assign settled       = since_pending >= {16'd0, cfg_i.debounce_ms};

  always_comb begin
    open_d     = open_q;
    level_d    = level_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    sample_t_d = sample_t_q;
    pv_d       = pv_q;
    ptc_d      = ptc_q;
    pst_d      = pst_q;
    res.changed         = 1'b0;
    res.sampled         = 1'b0;
    res.bounds_rejected = 1'b0;
    case (w.action)
      whdq_pkg::ACT_TICK: begin
        if (take) begin
          res.sampled = 1'b1;
          sample_t_d  = w.now_ms;
          level_d     = w.avg;
          if (!c_closed && !c_open) begin
            pv_d = 1'b0;
          end else if (c_closed != open_q) begin
            // class agrees with the current state: drop any pending change
            pv_d = 1'b0;
          end else if (!pv_q || (ptc_q != c_closed)) begin
            pv_d  = 1'b1;
            ptc_d = c_closed;
            pst_d = w.now_ms;
          end else if (settled) begin
            pv_d        = 1'b0;
            open_d      = ~c_closed;
            res.changed = 1'b1;
          end
        end
      end
      whdq_pkg::ACT_SET: begin
        if (!w.bounds_ok) begin
          res.bounds_rejected = 1'b1;
        end else begin
          lo_d = w.lo;
          hi_d = w.hi;
          pv_d = 1'b0;
          if (c_closed) begin
            open_d = 1'b0;
          end else if (c_open) begin
            open_d = 1'b1;
          end
        end
      end
      whdq_pkg::ACT_START: begin
        res.bounds_rejected = ~w.bounds_ok;
        lo_d    = w.lo;
        hi_d    = w.hi;
        level_d = w.avg;
        open_d  = c_open;
      end
      default: ;
    endcase
    res.state_open = open_d;
    res.level      = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      level_q    <= 12'd0;
      lo_q       <= whdq_pkg::DefLoReset;
      hi_q       <= whdq_pkg::DefHiReset;
      sample_t_q <= 32'd0;
      pv_q       <= 1'b0;
      ptc_q      <= 1'b0;
      pst_q      <= 32'd0;
    end else if (go) begin
      open_q     <= open_d;
      level_q    <= level_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      sample_t_q <= sample_t_d;
      pv_q       <= pv_d;
      ptc_q      <= ptc_d;
      pst_q      <= pst_d;
    end
  end

  // Result queue
  assign empty   = (ocnt_q == 2'd0);
  assign out_o   = omem_q[orptr_q];
  assign do_opop = pop & ~empty;

  always_comb begin
    owptr_d = owptr_q ^ go;
    orptr_d = orptr_q ^ do_opop;
    ocnt_d  = ocnt_q + {1'b0, go} - {1'b0, do_opop};
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      omem_q[owptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= 1'b0;
      orptr_q <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      owptr_q <= owptr_d;
      orptr_q <= orptr_d;
      ocnt_q  <= ocnt_d;
    end
  end

endmodule

`default_nettype wire
